>>> sv/mbb_pkg.sv
package mbb_pkg;

    localparam int SCREEN_WIDTH   = 720;
    localparam int SCREEN_HEIGHT  = 348;
    localparam int BYTES_PER_LINE = 90;
    localparam int BANK_BYTES     = 8192;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam logic [2:0] REG_DEST_X        = 3'd0;
    localparam logic [2:0] REG_DEST_Y        = 3'd1;
    localparam logic [2:0] REG_BLIT_WIDTH    = 3'd2;
    localparam logic [2:0] REG_BLIT_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_SOURCE_FORMAT = 3'd4;
    localparam logic [2:0] REG_FG_ON         = 3'd5;
    localparam logic [2:0] REG_BG_ON         = 3'd6;

    localparam logic [2:0] FMT_NATIVE = 3'd0;
    localparam logic [2:0] FMT_FGBG   = 3'd1;
    localparam logic [2:0] FMT_GRAY2  = 3'd2;
    localparam logic [2:0] FMT_GRAY4  = 3'd3;
    localparam logic [2:0] FMT_GRAY8  = 3'd4;

    typedef struct packed {
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [10:0] blit_width;
        logic [10:0] blit_height;
        logic [2:0]  source_format;
        logic        fg_on;
        logic        bg_on;
    } cfg_t;

    // per source byte context handed to the lanes
    typedef struct packed {
        logic        active;
        logic        row_on;
        logic        aligned;
        logic [7:0]  src_byte;
        logic [13:0] colbase;
        logic [14:0] row_base;
    } hdr_t;

    typedef struct packed {
        logic        hit;
        logic [14:0] addr;
        logic [7:0]  mask;
        logic [7:0]  data;
    } lane_res_t;

    // log2 of pixels per source byte
    function automatic logic [1:0] ppb_log(input logic [2:0] fmt);
        logic [1:0] r;
        case (fmt) inside
            FMT_NATIVE, FMT_FGBG: r = 2'd3;
            FMT_GRAY2:            r = 2'd2;
            FMT_GRAY4:            r = 2'd1;
            default:              r = 2'd0;
        endcase
        return r;
    endfunction

    // gray values threshold at their top bit
    function automatic logic pixel_on(input logic [2:0] fmt, input logic [7:0] b,
                                      input logic [LANE_W-1:0] k, input logic fg,
                                      input logic bg);
        logic [5:0] amt;
        logic [7:0] sh;
        amt = 6'(k) << (2'd3 - ppb_log(fmt));
        sh  = b << amt;
        return (fmt == FMT_FGBG) ? (sh[7] ? fg : bg) : sh[7];
    endfunction

endpackage

>>> sv/mbb_if.sv
interface mbb_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink (input valid, input src_byte, output ready);
endinterface

interface mbb_dst_if;
    logic        valid;
    logic        ready;
    logic [14:0] byte_address;
    logic [7:0]  write_mask;
    logic [7:0]  write_data;
    logic        last_of_byte;

    modport source (output valid, output byte_address, output write_mask,
                    output write_data, output last_of_byte, input ready);
    modport sink (input valid, input byte_address, input write_mask,
                  input write_data, input last_of_byte, output ready);
endinterface

>>> sv/mono_banked_bitmap_blit.sv
// Monochrome bitmap blit into a four-bank interleaved framebuffer. Source bytes
// come in on src (1bpp, 1bpp fg/bg, 2bpp, 4bpp or 8bpp gray, rows padded to whole
// bytes); each on-screen pixel becomes one masked byte write on dst, and an
// aligned 1bpp native blit writes each source byte whole. Eight pixel lanes
// decode a byte combinationally, and the write serializer then issues one write
// per cycle while dst is ready; a byte makes at most 8 writes. Bytes are taken
// back to back while earlier writes drain; a byte passes the header, bundle and
// output registers before its first write. Registers (cfg_index 0..6: dest_x,
// dest_y, blit_width, blit_height, source_format, fg_on, bg_on) must be written by
// the user only while idle; the block does not enforce it. Every write to one of
// them restarts the bitmap at row 0, byte 0.
module mono_banked_bitmap_blit
    import mbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    mbb_src_if.sink     src,
    mbb_dst_if.source   dst
);

    cfg_t      cfg;
    hdr_t      hdr;
    logic      hdr_valid;
    logic      take;
    lane_res_t res [LANES];

    mbb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src),
        .take      (take),
        .cfg       (cfg),
        .hdr       (hdr),
        .hdr_valid (hdr_valid)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        mbb_lane u_lane (
            .cfg      (cfg),
            .hdr      (hdr),
            .lane_idx (LANE_W'(g)),
            .res      (res[g])
        );
    end

    mbb_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .res       (res),
        .take      (take),
        .dst       (dst)
    );

endmodule

>>> sv/mbb_front.sv
module mbb_front
    import mbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    mbb_src_if.sink     src,
    input  logic        take,
    output cfg_t        cfg,
    output hdr_t        hdr,
    output logic        hdr_valid
);

    cfg_t        cfg_reg, cfg_next;
    logic        cfg_clr;
    logic [10:0] row_reg, row_next;
    logic [10:0] bir_reg, bir_next;
    logic        hdr_valid_reg, hdr_valid_next;
    hdr_t        hdr_reg, hdr_next;

    logic [10:0]        bpr;
    logic [11:0]        w_ext;
    logic               active;
    logic               accept;
    logic signed [12:0] py;
    logic [14:0]        bank_part;
    logic [14:0]        line_part;

    assign w_ext  = {1'b0, cfg_reg.blit_width};
    assign accept = src.valid && src.ready;
    assign src.ready = !hdr_valid_reg || take;

    always_comb
    begin
        case (cfg_reg.source_format) inside
            FMT_NATIVE, FMT_FGBG: bpr = 11'((w_ext + 12'd7) >> 3);
            FMT_GRAY2:            bpr = 11'((w_ext + 12'd3) >> 2);
            FMT_GRAY4:            bpr = 11'((w_ext + 12'd1) >> 1);
            FMT_GRAY8:            bpr = cfg_reg.blit_width;
            default:              bpr = 11'd0;
        endcase
    end

    assign active = (bpr != 11'd0) && (row_reg < cfg_reg.blit_height);

    // row address part is shared by all lanes
    assign py = $signed({cfg_reg.dest_y[11], cfg_reg.dest_y}) + $signed({2'b00, row_reg});
    assign bank_part = 15'(32'(py[1:0]) * BANK_BYTES);
    assign line_part = 15'(32'(py[12:2]) * BYTES_PER_LINE);

    always_comb
    begin
        hdr_next          = hdr_reg;
        hdr_next.active   = active;
        hdr_next.row_on   = !py[12] && (py < 13'(SCREEN_HEIGHT));
        hdr_next.aligned  = (cfg_reg.source_format == FMT_NATIVE)
                            && (cfg_reg.dest_x[2:0] == 3'd0)
                            && (cfg_reg.blit_width[2:0] == 3'd0);
        hdr_next.src_byte = src.src_byte;
        hdr_next.colbase  = {3'b000, bir_reg} << ppb_log(cfg_reg.source_format);
        hdr_next.row_base = 15'(bank_part + line_part);
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_clr  = 1'b0;
        if (cfg_we)
        begin
            cfg_clr = 1'b1;
            unique case (cfg_index)
                REG_DEST_X:        cfg_next.dest_x = cfg_data;
                REG_DEST_Y:        cfg_next.dest_y = cfg_data;
                REG_BLIT_WIDTH:    cfg_next.blit_width = cfg_data[10:0];
                REG_BLIT_HEIGHT:   cfg_next.blit_height = cfg_data[10:0];
                REG_SOURCE_FORMAT: cfg_next.source_format = cfg_data[2:0];
                REG_FG_ON:         cfg_next.fg_on = cfg_data[0];
                REG_BG_ON:         cfg_next.bg_on = cfg_data[0];
                default:           cfg_clr = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        row_next = row_reg;
        bir_next = bir_reg;
        if (cfg_clr)
        begin
            row_next = 11'd0;
            bir_next = 11'd0;
        end
        else if (accept && active)
        begin
            if (({1'b0, bir_reg} + 12'd1) >= {1'b0, bpr})
            begin
                bir_next = 11'd0;
                row_next = row_reg + 11'd1;
            end
            else
            begin
                bir_next = bir_reg + 11'd1;
            end
        end
    end

    always_comb
    begin
        if (accept)
            hdr_valid_next = 1'b1;
        else if (take)
            hdr_valid_next = 1'b0;
        else
            hdr_valid_next = hdr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{dest_x: 12'd0, dest_y: 12'd0, blit_width: 11'd0,
                               blit_height: 11'd0, source_format: FMT_NATIVE,
                               fg_on: 1'b1, bg_on: 1'b0};
            row_reg       <= 11'd0;
            bir_reg       <= 11'd0;
            hdr_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            row_reg       <= row_next;
            bir_reg       <= bir_next;
            hdr_valid_reg <= hdr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hdr_reg <= hdr_next;
    end

    assign cfg       = cfg_reg;
    assign hdr       = hdr_reg;
    assign hdr_valid = hdr_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (bir_reg != 11'd0) |-> (bir_reg < bpr))
        else $error("byte position ran past the row");

    assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= cfg_reg.blit_height)
        else $error("row count ran past the bitmap height");

endmodule

>>> sv/mbb_lane.sv
module mbb_lane
    import mbb_pkg::*;
(
    input  cfg_t              cfg,
    input  hdr_t              hdr,
    input  logic [LANE_W-1:0] lane_idx,
    output lane_res_t         res
);

    logic [13:0]        col;
    logic signed [16:0] px;
    logic               lane_used;
    logic               px_ok;
    logic               on;
    logic [7:0]         pmask;
    logic signed [12:0] col_a;
    logic               col_a_ok;

    assign col       = hdr.colbase + 14'(lane_idx);
    assign px        = $signed({{5{cfg.dest_x[11]}}, cfg.dest_x}) + $signed({3'b000, col});
    assign lane_used = (lane_idx >> ppb_log(cfg.source_format)) == '0;
    assign px_ok     = lane_used && (col < {3'b000, cfg.blit_width})
                       && !px[16] && (px < 17'(SCREEN_WIDTH));
    assign on        = pixel_on(cfg.source_format, hdr.src_byte, lane_idx,
                                cfg.fg_on, cfg.bg_on);
    assign pmask     = 8'h80 >> px[2:0];

    // whole byte copy uses lane zero only
    assign col_a    = ($signed({cfg.dest_x[11], cfg.dest_x}) >>> 3)
                      + $signed({2'b00, hdr.colbase[13:3]});
    assign col_a_ok = (lane_idx == '0) && !col_a[12] && (col_a < 13'(BYTES_PER_LINE));

    always_comb
    begin
        if (hdr.aligned)
        begin
            res.hit  = hdr.active && hdr.row_on && col_a_ok;
            res.addr = 15'(hdr.row_base + 15'(col_a[6:0]));
            res.mask = 8'hFF;
            res.data = hdr.src_byte;
        end
        else
        begin
            res.hit  = hdr.active && hdr.row_on && px_ok;
            res.addr = 15'(hdr.row_base + 15'(px[9:3]));
            res.mask = pmask;
            res.data = on ? pmask : 8'h00;
        end
    end

endmodule

>>> sv/mbb_merge.sv
module mbb_merge
    import mbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hdr_valid,
    input  lane_res_t res [LANES],
    output logic      take,
    mbb_dst_if.source dst
);

    logic [LANES-1:0] pend_reg, pend_next;
    lane_res_t        bundle_reg [LANES];
    logic [LANES-1:0] pick;
    logic [LANES-1:0] rest;
    logic [LANES-1:0] pend_after;
    logic             move;
    logic             last;
    lane_res_t        sel;

    logic        out_valid_reg;
    logic [14:0] out_addr_reg;
    logic [7:0]  out_mask_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;

    // lowest pending lane goes out first, keeping pixel order
    assign pick       = pend_reg & (~pend_reg + 1'b1);
    assign rest       = pend_reg & ~pick;
    assign move       = (pend_reg != '0) && (!out_valid_reg || dst.ready);
    assign last       = rest == '0;
    assign pend_after = move ? rest : pend_reg;
    assign take       = pend_after == '0;

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (pick[i])
                sel = sel | bundle_reg[i];
        end
    end

    always_comb
    begin
        pend_next = pend_after;
        if (take)
        begin
            for (int i = 0; i < LANES; i++)
                pend_next[i] = hdr_valid && res[i].hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (move)
                out_valid_reg <= 1'b1;
            else if (dst.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hdr_valid)
        begin
            for (int i = 0; i < LANES; i++)
                bundle_reg[i] <= res[i];
        end
        if (move)
        begin
            out_addr_reg <= sel.addr;
            out_mask_reg <= sel.mask;
            out_data_reg <= sel.data;
            out_last_reg <= last;
        end
    end

    assign dst.valid        = out_valid_reg;
    assign dst.byte_address = out_addr_reg;
    assign dst.write_mask   = out_mask_reg;
    assign dst.write_data   = out_data_reg;
    assign dst.last_of_byte = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid |-> ((dst.write_data & ~dst.write_mask) == 8'h00))
        else $error("write data outside the mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid |-> ($onehot(dst.write_mask) || dst.write_mask == 8'hFF))
        else $error("mask is neither one pixel nor a whole byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (move && !last) |=> (pend_reg != '0))
        else $error("pending writes of a byte were dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_reg != '0) && !out_valid_reg) |-> move)
        else $error("output register idle while writes are pending");

endmodule
